// ----- hdl/sper_pkg.sv -----
// Shared types and constants for the shortest-path edge relaxer.
// Used by every module of the block; no dependencies.
package sper_pkg;

  localparam int VERTEX_COUNT_DEF  = 1024;
  localparam int DISTANCE_BITS_DEF = 32;

  localparam int CMD_BITS       = 2;
  localparam int VERTEX_BITS    = 10;
  localparam int WEIGHT_BITS    = 16;
  localparam int COUNT_BITS     = 16;
  localparam int OUT_DIST_BITS  = 32;
  localparam int MAXD_BITS      = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  // wide enough to compare a vertex index against any vertex count
  localparam int VCMP_BITS      = 21;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_LIMIT   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNIFORM = 2'd2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INIT     = 2'd0,
    CMD_RELAX    = 2'd1,
    CMD_END_PASS = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  // classified item handed from the front end to the execution unit
  typedef struct packed {
    cmd_e                   cmd;
    logic [VERTEX_BITS-1:0] src;
    logic [VERTEX_BITS-1:0] tgt;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   in_range;
  } op_t;

endpackage

// ----- hdl/sper_front.sv -----
// Front end: configuration registers, item classification and distance cap.
// Depends on sper_pkg.
module sper_front #(
  parameter int VERTEX_COUNT  = sper_pkg::VERTEX_COUNT_DEF,
  parameter int DISTANCE_BITS = sper_pkg::DISTANCE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sper_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [sper_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [sper_pkg::CMD_BITS-1:0]        command_i,
  input  logic [sper_pkg::VERTEX_BITS-1:0]     edge_source_i,
  input  logic [sper_pkg::VERTEX_BITS-1:0]     edge_target_i,
  input  logic [sper_pkg::WEIGHT_BITS-1:0]     edge_weight_i,
  input  logic                                 q_ready_i,
  output logic                                 q_push_o,
  output sper_pkg::op_t                        q_op_o,
  output logic [DISTANCE_BITS-1:0]             cap_o,
  output logic [sper_pkg::VERTEX_BITS-1:0]     source_o
);

  localparam int CW = ((DISTANCE_BITS > sper_pkg::MAXD_BITS) ? DISTANCE_BITS
                       : sper_pkg::MAXD_BITS) + 1;

  logic [sper_pkg::MAXD_BITS-1:0]   limit_q;
  logic [sper_pkg::VERTEX_BITS-1:0] source_q;
  logic                             uniform_q;
  logic [DISTANCE_BITS-1:0]         cap_q;
  logic [CW-1:0]                    max_w;
  logic [CW-1:0]                    mask_w;
  logic [DISTANCE_BITS-1:0]         cap_d;
  logic                             src_ok;
  logic                             tgt_ok;
  sper_pkg::cmd_e                   cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= '1;
      source_q  <= '0;
      uniform_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sper_pkg::CFG_LIMIT:   limit_q   <= cfg_data_i;
        sper_pkg::CFG_SOURCE:  source_q  <= cfg_data_i[sper_pkg::VERTEX_BITS-1:0];
        sper_pkg::CFG_UNIFORM: uniform_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // cap = min(configured limit, all ones of the table width)
  assign max_w  = CW'(limit_q);
  assign mask_w = CW'({DISTANCE_BITS{1'b1}});
  assign cap_d  = DISTANCE_BITS'((max_w < mask_w) ? max_w : mask_w);

  always_ff @(posedge clk_i) begin
    cap_q <= cap_d;
  end

  assign cap_o    = cap_q;
  assign source_o = source_q;

  assign cmd    = sper_pkg::cmd_e'(command_i);
  assign src_ok = sper_pkg::VCMP_BITS'(edge_source_i) < sper_pkg::VCMP_BITS'(VERTEX_COUNT);
  assign tgt_ok = sper_pkg::VCMP_BITS'(edge_target_i) < sper_pkg::VCMP_BITS'(VERTEX_COUNT);

  always_comb begin
    q_op_o.cmd      = cmd;
    q_op_o.src      = edge_source_i;
    q_op_o.tgt      = edge_target_i;
    q_op_o.weight   = uniform_q ? sper_pkg::WEIGHT_BITS'(1) : edge_weight_i;
    q_op_o.in_range = (cmd == sper_pkg::CMD_READ) ? src_ok : (src_ok && tgt_ok);
  end

  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i;

endmodule

// ----- hdl/sper_queue.sv -----
// Short queue of classified items between front end and execution unit.
// Depends on sper_pkg.
module sper_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sper_pkg::op_t push_op_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sper_pkg::op_t op_o
);

  sper_pkg::op_t                   slots_q [sper_pkg::QUEUE_DEPTH];
  logic [sper_pkg::QPTR_BITS-1:0]  wr_q;
  logic [sper_pkg::QPTR_BITS-1:0]  rd_q;
  logic [sper_pkg::QCNT_BITS-1:0]  cnt_q;
  logic                            do_push;
  logic                            do_pop;

  assign ready_o = cnt_q != sper_pkg::QCNT_BITS'(sper_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign op_o    = slots_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [sper_pkg::QPTR_BITS-1:0] next_ptr(
    input logic [sper_pkg::QPTR_BITS-1:0] p
  );
    return (p == sper_pkg::QPTR_BITS'(sper_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= next_ptr(wr_q);
      if (do_pop)  rd_q <= next_ptr(rd_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_q] <= push_op_i;
  end

endmodule

// ----- hdl/sper_back.sv -----
// Execution unit: distance table memory, relax/read/pass logic, result register.
// Depends on sper_pkg.
module sper_back #(
  parameter int VERTEX_COUNT  = sper_pkg::VERTEX_COUNT_DEF,
  parameter int DISTANCE_BITS = sper_pkg::DISTANCE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  sper_pkg::op_t                        q_op_i,
  output logic                                 q_pop_o,
  input  logic [DISTANCE_BITS-1:0]             cap_i,
  input  logic [sper_pkg::VERTEX_BITS-1:0]     source_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 was_updated_o,
  output logic [sper_pkg::OUT_DIST_BITS-1:0]   distance_value_o,
  output logic [sper_pkg::COUNT_BITS-1:0]      pass_changes_o,
  output logic                                 converged_o
);

  localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int SW = ((DISTANCE_BITS > sper_pkg::WEIGHT_BITS) ? DISTANCE_BITS
                       : sper_pkg::WEIGHT_BITS) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INIT = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [DISTANCE_BITS-1:0]         dist_mem [VERTEX_COUNT];
  logic [DISTANCE_BITS-1:0]         rd_src_q;
  logic [DISTANCE_BITS-1:0]         rd_tgt_q;
  logic [1:0]                       state_q;
  logic [AW-1:0]                    sweep_q;
  logic [sper_pkg::COUNT_BITS-1:0]  count_q;
  sper_pkg::op_t                    op_q;
  logic                             out_valid_q;
  logic                             out_free;
  logic                             pop;
  logic                             sweep_last;
  logic [SW-1:0]                    sum;
  logic                             upd;
  logic                             we;
  logic [AW-1:0]                    waddr;
  logic [DISTANCE_BITS-1:0]         wdata;
  logic [DISTANCE_BITS-1:0]         init_val;
  logic                             res_upd_d, res_upd_q;
  logic [sper_pkg::OUT_DIST_BITS-1:0] res_dist_d, res_dist_q;
  logic [sper_pkg::COUNT_BITS-1:0]  res_chg_d, res_chg_q;
  logic                             res_conv_d, res_conv_q;

  assign pop        = (state_q == S_IDLE) && q_valid_i;
  assign q_pop_o    = pop;
  assign sweep_last = sweep_q == AW'(VERTEX_COUNT - 1);
  assign out_free   = !out_valid_q || out_ready_i;

  assign init_val = (sper_pkg::VCMP_BITS'(sweep_q) == sper_pkg::VCMP_BITS'(source_i))
                    ? '0 : cap_i;

  // a relax lowers the target only if the new sum stays within the cap
  assign sum = SW'(rd_src_q) + SW'(op_q.weight);
  assign upd = (sum <= SW'(cap_i)) && (sum < SW'(rd_tgt_q));

  assign we    = (state_q == S_INIT) ||
                 ((state_q == S_EXEC) && (op_q.cmd == sper_pkg::CMD_RELAX) &&
                  op_q.in_range && upd);
  assign waddr = (state_q == S_INIT) ? sweep_q : AW'(op_q.tgt);
  assign wdata = (state_q == S_INIT) ? init_val : DISTANCE_BITS'(sum);

  always_ff @(posedge clk_i) begin
    if (we) dist_mem[waddr] <= wdata;
    if (pop) begin
      rd_src_q <= dist_mem[AW'(q_op_i.src)];
      rd_tgt_q <= dist_mem[AW'(q_op_i.tgt)];
    end
  end

  always_comb begin
    res_upd_d  = 1'b0;
    res_dist_d = '0;
    res_chg_d  = '0;
    res_conv_d = 1'b0;
    unique case (op_q.cmd)
      sper_pkg::CMD_INIT: ;
      sper_pkg::CMD_RELAX: begin
        if (op_q.in_range) begin
          res_upd_d  = upd;
          res_dist_d = upd ? sper_pkg::OUT_DIST_BITS'(sum)
                           : sper_pkg::OUT_DIST_BITS'(rd_tgt_q);
        end
      end
      sper_pkg::CMD_END_PASS: begin
        res_chg_d  = count_q;
        res_conv_d = count_q == '0;
      end
      sper_pkg::CMD_READ: begin
        if (op_q.in_range) res_dist_d = sper_pkg::OUT_DIST_BITS'(rd_src_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sweep_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            sweep_q <= '0;
            state_q <= (q_op_i.cmd == sper_pkg::CMD_INIT) ? S_INIT : S_EXEC;
          end
        end
        S_INIT: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_last) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (op_q.cmd == sper_pkg::CMD_END_PASS) begin
            count_q <= '0;
          end else if (we && (count_q != '1)) begin
            count_q <= count_q + 1'b1;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) op_q <= q_op_i;
    if (state_q == S_EXEC) begin
      res_upd_q  <= res_upd_d;
      res_dist_q <= res_dist_d;
      res_chg_q  <= res_chg_d;
      res_conv_q <= res_conv_d;
    end
    if ((state_q == S_EMIT) && out_free) begin
      was_updated_o    <= res_upd_q;
      distance_value_o <= res_dist_q;
      pass_changes_o   <= res_chg_q;
      converged_o      <= res_conv_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/shortest_path_edge_relaxer_core.sv -----
// Bellman-Ford edge relaxer over a VERTEX_COUNT-entry distance table held in a
// memory with two read ports and one write port. Items enter a two-entry queue,
// so the input side keeps accepting while a result waits, until it is full.
// Relax, read and end-of-pass items pass through the execution unit as table
// read, compare and write-back, then result stage; an init item sweeps the
// table one entry per cycle, then goes through the last two steps. Read
// distances only after an init. Configuration is taken every cycle (cfg_ready_o
// is always high). Depends on sper_pkg, sper_front, sper_queue, sper_back.
module shortest_path_edge_relaxer_core #(
  parameter int VERTEX_COUNT  = sper_pkg::VERTEX_COUNT_DEF,
  parameter int DISTANCE_BITS = sper_pkg::DISTANCE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sper_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [sper_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [sper_pkg::CMD_BITS-1:0]        command_i,
  input  logic [sper_pkg::VERTEX_BITS-1:0]     edge_source_i,
  input  logic [sper_pkg::VERTEX_BITS-1:0]     edge_target_i,
  input  logic [sper_pkg::WEIGHT_BITS-1:0]     edge_weight_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 was_updated_o,
  output logic [sper_pkg::OUT_DIST_BITS-1:0]   distance_value_o,
  output logic [sper_pkg::COUNT_BITS-1:0]      pass_changes_o,
  output logic                                 converged_o
);

  logic                              q_ready;
  logic                              q_push;
  sper_pkg::op_t                     push_op;
  logic                              q_valid;
  logic                              q_pop;
  sper_pkg::op_t                     head_op;
  logic [DISTANCE_BITS-1:0]          cap;
  logic [sper_pkg::VERTEX_BITS-1:0]  source;

  sper_front #(
    .VERTEX_COUNT  (VERTEX_COUNT),
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .edge_source_i (edge_source_i),
    .edge_target_i (edge_target_i),
    .edge_weight_i (edge_weight_i),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_op_o        (push_op),
    .cap_o         (cap),
    .source_o      (source)
  );

  sper_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .ready_o   (q_ready),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .op_o      (head_op)
  );

  sper_back #(
    .VERTEX_COUNT  (VERTEX_COUNT),
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_op_i           (head_op),
    .q_pop_o          (q_pop),
    .cap_i            (cap),
    .source_i         (source),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .was_updated_o    (was_updated_o),
    .distance_value_o (distance_value_o),
    .pass_changes_o   (pass_changes_o),
    .converged_o      (converged_o)
  );

endmodule

// ----- hdl/sper_checker.sv -----
// Port-level checks on the relaxer results, bound to the top level.
// Depends on sper_pkg and shortest_path_edge_relaxer_core.
module sper_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                was_updated_o,
  input logic [sper_pkg::OUT_DIST_BITS-1:0]  distance_value_o,
  input logic [sper_pkg::COUNT_BITS-1:0]     pass_changes_o,
  input logic                                converged_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(was_updated_o) &&
      $stable(distance_value_o) && $stable(pass_changes_o) && $stable(converged_o))
    else $error("result changed while stalled");

  a_upd_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_updated_o |-> pass_changes_o == '0 && !converged_o)
    else $error("relax result carries pass fields");

  a_conv_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && converged_o |->
      pass_changes_o == '0 && distance_value_o == '0 && !was_updated_o)
    else $error("converged result with nonzero fields");

  a_pass_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pass_changes_o != '0 |-> distance_value_o == '0)
    else $error("end-of-pass result carries a distance");

endmodule

bind shortest_path_edge_relaxer_core sper_checker u_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for shortest_path_edge_relaxer_core: directed table, then random passes.
// Results are checked against a distance-table predictor kept here. Depends on sper_pkg.
module testbench;

  localparam int LIMIT_CYCLES = 500_000;
  localparam int STALL_CYCLES = 300;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic                               upd;
    logic [sper_pkg::OUT_DIST_BITS-1:0] dval;
    logic [sper_pkg::COUNT_BITS-1:0]    chg;
    logic                               conv;
  } result_t;

  typedef struct packed {
    bit                                  wr_cfg;
    logic [sper_pkg::CFG_INDEX_BITS-1:0] reg_idx;
    logic [sper_pkg::CFG_DATA_BITS-1:0]  reg_val;
    sper_pkg::cmd_e                      cmd;
    logic [sper_pkg::VERTEX_BITS-1:0]    src;
    logic [sper_pkg::VERTEX_BITS-1:0]    tgt;
    logic [sper_pkg::WEIGHT_BITS-1:0]    wt;
    bit                                  typed;
    result_t                             want;
  } row_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [sper_pkg::CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [sper_pkg::CFG_DATA_BITS-1:0]  cfg_data_i;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic [sper_pkg::CMD_BITS-1:0]       command_i;
  logic [sper_pkg::VERTEX_BITS-1:0]    edge_source_i;
  logic [sper_pkg::VERTEX_BITS-1:0]    edge_target_i;
  logic [sper_pkg::WEIGHT_BITS-1:0]    edge_weight_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic                                was_updated_o;
  logic [sper_pkg::OUT_DIST_BITS-1:0]  distance_value_o;
  logic [sper_pkg::COUNT_BITS-1:0]     pass_changes_o;
  logic                                converged_o;

  // predictor state
  logic [sper_pkg::OUT_DIST_BITS-1:0] dist_tab [sper_pkg::VERTEX_COUNT_DEF];
  logic [sper_pkg::MAXD_BITS-1:0]     limit;
  logic [sper_pkg::VERTEX_BITS-1:0]   vsrc;
  logic                               unif;
  logic [sper_pkg::COUNT_BITS-1:0]    pass_cnt;

  result_t pending_results[$];
  row_t    plan[$];
  int      mismatches;
  bit      steady;
  bit      stall_req;
  bit      stall_done;

  shortest_path_edge_relaxer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .edge_source_i   (edge_source_i),
    .edge_target_i   (edge_target_i),
    .edge_weight_i   (edge_weight_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .was_updated_o   (was_updated_o),
    .distance_value_o(distance_value_o),
    .pass_changes_o  (pass_changes_o),
    .converged_o     (converged_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic result_t predict_distance_op(sper_pkg::cmd_e c,
                                                  logic [sper_pkg::VERTEX_BITS-1:0] s,
                                                  logic [sper_pkg::VERTEX_BITS-1:0] t,
                                                  logic [sper_pkg::WEIGHT_BITS-1:0] w);
    result_t                          r;
    logic [sper_pkg::OUT_DIST_BITS:0] sum;
    int                               v;
    r = '0;
    case (c)
      sper_pkg::CMD_INIT: begin
        for (v = 0; v < sper_pkg::VERTEX_COUNT_DEF; v++) begin
          dist_tab[v] = (v == vsrc) ? '0 : limit;
        end
      end
      sper_pkg::CMD_RELAX: begin
        // one extra bit so a sum past the cap never wraps
        sum = {1'b0, dist_tab[s]} + (unif ? 33'd1 : {17'd0, w});
        if (sum <= {1'b0, limit} && sum < {1'b0, dist_tab[t]}) begin
          dist_tab[t] = sum[sper_pkg::OUT_DIST_BITS-1:0];
          if (pass_cnt != '1) pass_cnt++;
          r.upd = 1'b1;
        end
        r.dval = dist_tab[t];
      end
      sper_pkg::CMD_END_PASS: begin
        r.chg    = pass_cnt;
        r.conv   = (pass_cnt == 0);
        pass_cnt = '0;
      end
      default: begin
        r.dval = dist_tab[s];
      end
    endcase
    return r;
  endfunction

  function automatic void plan_reg(logic [sper_pkg::CFG_INDEX_BITS-1:0] idx,
                                   logic [sper_pkg::CFG_DATA_BITS-1:0] val);
    row_t r;
    r         = '0;
    r.wr_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void plan_op(sper_pkg::cmd_e c, logic [sper_pkg::VERTEX_BITS-1:0] s,
                                  logic [sper_pkg::VERTEX_BITS-1:0] t,
                                  logic [sper_pkg::WEIGHT_BITS-1:0] w);
    row_t r;
    r     = '0;
    r.cmd = c;
    r.src = s;
    r.tgt = t;
    r.wt  = w;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void plan_known(sper_pkg::cmd_e c, logic [sper_pkg::VERTEX_BITS-1:0] s,
                                     logic [sper_pkg::VERTEX_BITS-1:0] t,
                                     logic [sper_pkg::WEIGHT_BITS-1:0] w, logic upd,
                                     logic [sper_pkg::OUT_DIST_BITS-1:0] dval,
                                     logic [sper_pkg::COUNT_BITS-1:0] chg, logic conv);
    row_t r;
    r       = '0;
    r.cmd   = c;
    r.src   = s;
    r.tgt   = t;
    r.wt    = w;
    r.typed = 1'b1;
    r.want  = '{upd: upd, dval: dval, chg: chg, conv: conv};
    plan.insert(plan.size(), r);
  endfunction

  // entered just after a falling edge, returns just after one
  task automatic send_cmd(sper_pkg::cmd_e c, logic [sper_pkg::VERTEX_BITS-1:0] s,
                          logic [sper_pkg::VERTEX_BITS-1:0] t,
                          logic [sper_pkg::WEIGHT_BITS-1:0] w, bit typed, result_t want);
    result_t r;
    while (!steady && $urandom_range(0, 99) < 18) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    command_i     = c;
    edge_source_i = s;
    edge_target_i = t;
    edge_weight_i = w;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_distance_op(c, s, t, w);
    pending_results.insert(pending_results.size(), typed ? want : r);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [sper_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [sper_pkg::CFG_DATA_BITS-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sper_pkg::CFG_LIMIT:   limit = val;
      sper_pkg::CFG_SOURCE:  vsrc  = val[sper_pkg::VERTEX_BITS-1:0];
      sper_pkg::CFG_UNIFORM: unif  = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // every item yields one result, so an empty queue means the block is idle
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [sper_pkg::VERTEX_BITS-1:0] pool [12];
    logic [sper_pkg::MAXD_BITS-1:0]   maxv;
    logic [sper_pkg::VERTEX_BITS-1:0] s;
    logic [sper_pkg::VERTEX_BITS-1:0] t;
    logic [sper_pkg::WEIGHT_BITS-1:0] w;
    int                               phase;
    int                               k;
    int                               roll;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    command_i     = '0;
    edge_source_i = '0;
    edge_target_i = '0;
    edge_weight_i = '0;
    steady        = 1'b0;
    stall_req     = 1'b0;
    limit         = '1;
    vsrc          = '0;
    unif          = 1'b1;
    pass_cnt      = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: cap at all ones, source 0, unit weights
    plan_known(sper_pkg::CMD_INIT,     10'd0,    10'd0,    16'd0,    0, 32'd0,    16'd0, 0);
    plan_known(sper_pkg::CMD_READ,     10'd0,    10'd0,    16'd0,    0, 32'd0,    16'd0, 0);
    plan_known(sper_pkg::CMD_READ,     10'd1023, 10'd0,    16'd0,    0, '1,       16'd0, 0);
    plan_known(sper_pkg::CMD_END_PASS, 10'd0,    10'd0,    16'd0,    0, 32'd0,    16'd0, 1);
    plan_known(sper_pkg::CMD_RELAX,    10'd0,    10'd5,    16'hFFFF, 1, 32'd1,    16'd0, 0);
    plan_known(sper_pkg::CMD_RELAX,    10'd5,    10'd1023, 16'd0,    1, 32'd2,    16'd0, 0);
    plan_op   (sper_pkg::CMD_RELAX,    10'd1023, 10'd5,    16'h8000);
    plan_op   (sper_pkg::CMD_RELAX,    10'd0,    10'd0,    16'd0);
    // unreached source: sum runs past the cap
    plan_known(sper_pkg::CMD_RELAX,    10'd7,    10'd8,    16'd1,    0, '1,       16'd0, 0);
    plan_known(sper_pkg::CMD_READ,     10'd1023, 10'd0,    16'd0,    0, 32'd2,    16'd0, 0);
    plan_known(sper_pkg::CMD_END_PASS, 10'd0,    10'd0,    16'd0,    0, 32'd0,    16'd2, 0);
    plan_known(sper_pkg::CMD_END_PASS, 10'd0,    10'd0,    16'd0,    0, 32'd0,    16'd0, 1);
    plan_reg(sper_pkg::CFG_UNIFORM, 32'd0);
    plan_reg(sper_pkg::CFG_SOURCE,  32'd1023);
    plan_reg(sper_pkg::CFG_LIMIT,   32'd1000);
    plan_known(sper_pkg::CMD_INIT,     10'd0,    10'd0,    16'd0,    0, 32'd0,    16'd0, 0);
    plan_known(sper_pkg::CMD_READ,     10'd1023, 10'd0,    16'd0,    0, 32'd0,    16'd0, 0);
    plan_known(sper_pkg::CMD_READ,     10'd0,    10'd0,    16'd0,    0, 32'd1000, 16'd0, 0);
    plan_known(sper_pkg::CMD_RELAX,    10'd1023, 10'd0,    16'hFFFF, 0, 32'd1000, 16'd0, 0);
    plan_known(sper_pkg::CMD_RELAX,    10'd1023, 10'd0,    16'd999,  1, 32'd999,  16'd0, 0);
    plan_op   (sper_pkg::CMD_RELAX,    10'd1023, 10'd0,    16'd0);
    // equal to the target: not lower
    plan_known(sper_pkg::CMD_RELAX,    10'd1023, 10'd3,    16'd1000, 0, 32'd1000, 16'd0, 0);
    plan_op   (sper_pkg::CMD_RELAX,    10'd1023, 10'd3,    16'd500);
    plan_op   (sper_pkg::CMD_RELAX,    10'd3,    10'd4,    16'd500);
    // cap lowered after init
    plan_reg(sper_pkg::CFG_LIMIT, 32'd1);
    plan_op   (sper_pkg::CMD_RELAX,    10'd3,    10'd4,    16'd0);
    plan_op   (sper_pkg::CMD_RELAX,    10'd0,    10'd4,    16'd1);
    plan_op   (sper_pkg::CMD_END_PASS, 10'd0,    10'd0,    16'd0);

    foreach (plan[i]) begin
      if (plan[i].wr_cfg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_cmd(plan[i].cmd, plan[i].src, plan[i].tgt, plan[i].wt, plan[i].typed,
                 plan[i].want);
      end
    end

    for (phase = 0; phase < 8; phase++) begin
      drain();
      case (phase % 4)
        0: maxv = '1;
        1: maxv = 32'd1;
        2: maxv = 32'($urandom_range(2, 300));
        default: begin
          maxv = $urandom;
          if (maxv == 0) maxv = 32'd1;
        end
      endcase
      write_reg(sper_pkg::CFG_LIMIT, maxv);
      write_reg(sper_pkg::CFG_SOURCE, 32'($urandom_range(0, sper_pkg::VERTEX_COUNT_DEF - 1)));
      write_reg(sper_pkg::CFG_UNIFORM, 32'($urandom_range(0, 1)));
      pool[0] = vsrc;
      for (k = 1; k < 12; k++) begin
        pool[k] = 10'($urandom_range(0, sper_pkg::VERTEX_COUNT_DEF - 1));
      end
      steady = (phase == 5);
      send_cmd(sper_pkg::CMD_INIT, '0, '0, '0, 0, '0);
      for (k = 0; k < 160; k++) begin
        if (phase == 1 && k == 20) stall_req = 1'b1;
        if (k == 80 && $urandom_range(0, 1) == 1) begin
          drain();
          write_reg(sper_pkg::CFG_LIMIT, $urandom_range(1, limit));
        end
        roll = $urandom_range(0, 99);
        s    = pool[$urandom_range(0, 11)];
        t    = pool[$urandom_range(0, 11)];
        w    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        if (roll < 70) begin
          send_cmd(sper_pkg::CMD_RELAX, s, t, w, 0, '0);
        end else if (roll < 78) begin
          send_cmd(sper_pkg::CMD_END_PASS, 10'($urandom), 10'($urandom), 16'($urandom), 0,
                   '0);
        end else if (roll < 88) begin
          if (roll < 83) s = 10'($urandom);
          send_cmd(sper_pkg::CMD_READ, s, 10'($urandom), 16'($urandom), 0, '0);
        end else if (roll < 97) begin
          send_cmd(sper_pkg::CMD_RELAX, 10'($urandom), 10'($urandom), 16'($urandom), 0, '0);
        end else begin
          send_cmd(sper_pkg::CMD_INIT, 10'($urandom), 10'($urandom), 16'($urandom), 0, '0);
        end
      end
    end
    steady     = 1'b0;
    in_valid_i = 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : result_sink
    out_ready_i = 1'b0;
    stall_done  = 1'b0;
    forever begin
      @(negedge clk_i);
      // one long hold-off so the input queue fills and backs up
      if (stall_req && !stall_done) begin
        out_ready_i = 1'b0;
        repeat (STALL_CYCLES) @(negedge clk_i);
        stall_done = 1'b1;
      end
      out_ready_i = steady || ($urandom_range(0, 99) >= 18);
    end
  end

  initial mismatches = 0;

  always @(posedge clk_i) begin : result_check
    result_t want;
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{upd: was_updated_o, dval: distance_value_o, chg: pass_changes_o,
              conv: converged_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: unexpected item upd=%0b dval=%0d chg=%0d conv=%0b", $realtime,
                   got.upd, got.dval, got.chg, got.conv);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.upd !== want.upd || got.dval !== want.dval || got.chg !== want.chg ||
            got.conv !== want.conv) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: mismatch upd %0b/%0b dval %0d/%0d chg %0d/%0d conv %0b/%0b",
                     $realtime, want.upd, got.upd, want.dval, got.dval, want.chg, got.chg,
                     want.conv, got.conv);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
